FILE: sv/acsg_pkg.sv
`default_nettype none

package acsg_pkg;

    localparam int DEF_MAX_FRAME_SAMPLES = 8192;
    localparam int DEF_MAX_WINDOW_FRAMES = 64;
    localparam int RAMP_STEPS = 480;
    localparam int PHASE_W = $clog2(RAMP_STEPS + 1);
    localparam int GAIN_W = 17;
    localparam int MAX_CHANNELS = 8;
    localparam int FRAME_E_W = 44;
    localparam int WIN_E_W = 50;
    localparam int SQ_W = 31;
    localparam int ADDR_W = 5;

    localparam longint unsigned Q30_ONE = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam logic [2:0] REG_GATE_ENABLE = 3'd0;
    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd1;
    localparam logic [2:0] REG_FRAME_SAMPLES = 3'd2;
    localparam logic [2:0] REG_WINDOW_FRAMES = 3'd3;
    localparam logic [2:0] REG_PEAK_LIMIT = 3'd4;
    localparam logic [2:0] REG_QUIET_LIMIT = 3'd5;
    localparam logic [2:0] REG_HOLD_FRAMES = 3'd6;

    typedef struct packed {
        logic signed [15:0] sample_in;
        logic               gate_armed;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               frame_zeroed;
        logic               gate_closing;
    } out_item_t;

    typedef struct packed {
        logic        gate_enable;
        logic [3:0]  channel_count;
        logic [13:0] frame_samples;
        logic [6:0]  window_frames;
        logic [14:0] peak_limit;
        logic [29:0] quiet_energy_limit;
        logic [7:0]  hold_frames;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        gate_enable: 1'b1,
        channel_count: 4'd2,
        frame_samples: 14'd480,
        window_frames: 7'd40,
        peak_limit: 15'd31785,
        quiet_energy_limit: 30'd1074,
        hold_frames: 8'd60
    };

    typedef struct packed {
        logic signed [15:0] delayed;
        logic [15:0]        mag;
        logic [SQ_W-1:0]    sq;
        logic               armed;
        logic               last;
    } q_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GAIN,
        ST_MUL,
        ST_OUT,
        ST_LIM1,
        ST_LIM2,
        ST_DEC,
        ST_POP_RD,
        ST_POP_SUB,
        ST_PUSH
    } back_state_t;

    // Raised-cosine gain of one ramp phase; only evaluated for constant phases.
    function automatic logic [GAIN_W-1:0] ramp_gain(input int unsigned p);
        longint unsigned t;
        longint unsigned t2;
        longint unsigned f;
        longint unsigned s;
        longint unsigned g;
        if (p >= RAMP_STEPS) begin
            return GAIN_W'(32768);
        end
        t = (HALF_PI_Q30 * 64'(p)) / RAMP_STEPS;
        t2 = (t * t) >> 30;
        f = Q30_ONE - ((t2 * Q30_ONE) >> 30) / 110;
        f = Q30_ONE - ((t2 * f) >> 30) / 72;
        f = Q30_ONE - ((t2 * f) >> 30) / 42;
        f = Q30_ONE - ((t2 * f) >> 30) / 20;
        f = Q30_ONE - ((t2 * f) >> 30) / 6;
        s = (t * f) >> 30;
        if (s > Q30_ONE) begin
            s = Q30_ONE;
        end
        g = (s * s) >> 30;
        g = (g + 64'd16384) >> 15;
        if (g > 64'd32768) begin
            g = 64'd32768;
        end
        return GAIN_W'(g);
    endfunction

endpackage

`default_nettype wire

FILE: sv/acsg_front.sv
`default_nettype none

module acsg_front #(
    parameter int MAX_FRAME_SAMPLES = acsg_pkg::DEF_MAX_FRAME_SAMPLES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  acsg_pkg::in_item_t                 item,
    input  logic [$clog2(MAX_FRAME_SAMPLES):0] flen,
    output logic                               push_valid,
    input  logic                               push_ready,
    output acsg_pkg::q_entry_t                 push_data
);
    import acsg_pkg::*;

    localparam int POS_W = $clog2(MAX_FRAME_SAMPLES);
    localparam int FLEN_W = POS_W + 1;

    logic signed [15:0] delay_mem [MAX_FRAME_SAMPLES];
    logic signed [15:0] delayed_reg;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   clr_addr_reg, clr_addr_next;
    logic               clr_busy_reg, clr_busy_next;
    logic               s1_valid_reg, s1_valid_next;
    logic [15:0]        mag_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic               armed_reg;
    logic               last_reg;
    logic               accept;
    logic               at_end;
    logic [15:0]        raw;
    logic [15:0]        mag_now;
    logic signed [31:0] sq_now;

    assign item_ready = !clr_busy_reg && (!s1_valid_reg || push_ready);
    assign accept = item_valid && item_ready;
    assign raw = item.sample_in;
    assign mag_now = raw[15] ? (~raw + 16'd1) : raw;
    assign sq_now = item.sample_in * item.sample_in;
    assign at_end = (FLEN_W'(pos_reg) + FLEN_W'(1)) >= flen;

    always_comb
    begin
        pos_next = pos_reg;
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        s1_valid_next = s1_valid_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + POS_W'(1);
            if (clr_addr_reg == POS_W'(MAX_FRAME_SAMPLES - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
        if (accept)
        begin
            pos_next = at_end ? '0 : pos_reg + POS_W'(1);
            s1_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            clr_addr_reg <= clr_addr_next;
            clr_busy_reg <= clr_busy_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            delay_mem[clr_addr_reg] <= '0;
        end
        else if (accept)
        begin
            delayed_reg <= delay_mem[pos_reg];
            delay_mem[pos_reg] <= item.sample_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mag_reg <= mag_now;
            sq_reg <= sq_now[SQ_W-1:0];
            armed_reg <= item.gate_armed;
            last_reg <= at_end;
        end
    end

    assign push_valid = s1_valid_reg;
    assign push_data = '{
        delayed: delayed_reg,
        mag: mag_reg,
        sq: sq_reg,
        armed: armed_reg,
        last: last_reg
    };

endmodule

`default_nettype wire

FILE: sv/acsg_queue.sv
`default_nettype none

module acsg_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  acsg_pkg::q_entry_t push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output acsg_pkg::q_entry_t pop_data
);
    import acsg_pkg::*;

    q_entry_t   entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_push = push_valid && push_ready;
    assign do_pop = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: sv/acsg_back.sv
`default_nettype none

module acsg_back #(
    parameter int MAX_FRAME_SAMPLES = acsg_pkg::DEF_MAX_FRAME_SAMPLES,
    parameter int MAX_WINDOW_FRAMES = acsg_pkg::DEF_MAX_WINDOW_FRAMES
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  acsg_pkg::cfg_t                       cfg,
    input  logic [3:0]                           chans,
    input  logic [$clog2(MAX_FRAME_SAMPLES):0]   flen,
    input  logic [$clog2(MAX_WINDOW_FRAMES+1)-1:0] wlen,
    input  logic                                 pop_valid,
    output logic                                 pop_ready,
    input  acsg_pkg::q_entry_t                   pop_data,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output acsg_pkg::out_item_t                  result
);
    import acsg_pkg::*;

    localparam int FLEN_W = $clog2(MAX_FRAME_SAMPLES) + 1;
    localparam int FILL_W = $clog2(MAX_WINDOW_FRAMES + 1);
    localparam int HEAD_W = (MAX_WINDOW_FRAMES > 1) ? $clog2(MAX_WINDOW_FRAMES) : 1;
    localparam int MUL_W = FILL_W + FLEN_W;
    localparam int LIM_W = 30 + MUL_W;
    localparam int CMP_W = (LIM_W > WIN_E_W) ? LIM_W : WIN_E_W;

    logic [GAIN_W-1:0] gain_rom [RAMP_STEPS+1];

    for (genvar i = 0; i <= RAMP_STEPS; i++)
    begin : g_rom
        assign gain_rom[i] = ramp_gain(i);
    end

    logic [FRAME_E_W-1:0] ring_mem [MAX_WINDOW_FRAMES];

    back_state_t          state_reg, state_next;
    q_entry_t             it_reg, it_next;
    logic [GAIN_W-1:0]    gain_reg;
    logic signed [33:0]   prod_reg;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [2:0]           group_reg, group_next;
    logic [7:0]           hold_reg, hold_next;
    logic                 zero_reg, zero_next;
    logic                 gate_reg, gate_next;
    logic [15:0]          peak_reg, peak_next;
    logic [FRAME_E_W-1:0] fe_reg, fe_next;
    logic [WIN_E_W-1:0]   wen_reg, wen_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [HEAD_W-1:0]    head_reg, head_next;
    logic [MUL_W-1:0]     flmul_reg;
    logic [LIM_W-1:0]     limit_reg;
    logic [FRAME_E_W-1:0] ring_rd_reg;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_data_reg, out_data_next;

    logic                 out_free;
    logic                 do_pop;
    logic                 do_out;
    logic                 ring_re;
    logic                 ring_we;
    logic                 need_pop;
    logic [FILL_W:0]      wr_sum;
    logic [HEAD_W-1:0]    wr_idx;
    logic signed [33:0]   rounded;
    logic signed [15:0]   y;
    logic [FRAME_E_W:0]   fe_sum;
    logic [WIN_E_W:0]     wen_sum;
    logic [3:0]           group_inc;
    logic                 quiet;
    logic                 active;

    assign out_free = !out_valid_reg || result_ready;
    assign need_pop = (fill_reg >= wlen);
    assign wr_sum = (FILL_W+1)'(head_reg) + (FILL_W+1)'(fill_reg);
    assign wr_idx = (wr_sum >= (FILL_W+1)'(MAX_WINDOW_FRAMES))
                    ? HEAD_W'(wr_sum - (FILL_W+1)'(MAX_WINDOW_FRAMES))
                    : HEAD_W'(wr_sum);
    assign rounded = prod_reg + 34'sd16384;
    assign fe_sum = {1'b0, fe_reg} + (FRAME_E_W+1)'(pop_data.sq);
    assign wen_sum = {1'b0, wen_reg} + (WIN_E_W+1)'(fe_reg);
    assign group_inc = {1'b0, group_reg} + 4'd1;
    assign quiet = (fill_reg == '0) || (CMP_W'(wen_reg) < CMP_W'(limit_reg));
    assign active = it_reg.armed || (hold_reg != 8'd0);

    always_comb
    begin
        if (!cfg.gate_enable)
        begin
            y = it_reg.delayed;
        end
        else if (zero_reg)
        begin
            y = '0;
        end
        else
        begin
            y = rounded[30:15];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = (it_reg.last && cfg.gate_enable) ? ST_LIM1 : ST_IDLE;
                end
            end
            ST_LIM1:
            begin
                state_next = ST_LIM2;
            end
            ST_LIM2:
            begin
                state_next = ST_DEC;
            end
            ST_DEC:
            begin
                state_next = ST_POP_RD;
            end
            ST_POP_RD:
            begin
                state_next = need_pop ? ST_POP_SUB : ST_PUSH;
            end
            ST_POP_SUB:
            begin
                state_next = ST_POP_RD;
            end
            ST_PUSH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop_ready = 1'b0;
        do_out = 1'b0;
        ring_re = 1'b0;
        ring_we = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                pop_ready = 1'b1;
            end
            ST_OUT:
            begin
                do_out = out_free;
            end
            ST_POP_RD:
            begin
                ring_re = need_pop;
            end
            ST_PUSH:
            begin
                ring_we = 1'b1;
            end
            default:
            begin
                pop_ready = 1'b0;
            end
        endcase
    end

    assign do_pop = pop_valid && pop_ready;

    always_comb
    begin
        it_next = it_reg;
        phase_next = phase_reg;
        group_next = group_reg;
        hold_next = hold_reg;
        zero_next = zero_reg;
        gate_next = gate_reg;
        peak_next = peak_reg;
        fe_next = fe_reg;
        wen_next = wen_reg;
        fill_next = fill_reg;
        head_next = head_reg;
        out_valid_next = out_valid_reg;
        out_data_next = out_data_reg;

        if (result_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (do_pop)
        begin
            it_next = pop_data;
            if (cfg.gate_enable && !zero_reg && (group_reg == 3'd0))
            begin
                if (gate_reg)
                begin
                    if (phase_reg != '0)
                    begin
                        phase_next = phase_reg - PHASE_W'(1);
                    end
                end
                else if (phase_reg < PHASE_W'(RAMP_STEPS))
                begin
                    phase_next = phase_reg + PHASE_W'(1);
                end
            end
            if (pop_data.last || (group_inc >= chans))
            begin
                group_next = 3'd0;
            end
            else
            begin
                group_next = group_inc[2:0];
            end
            if (cfg.gate_enable)
            begin
                if (pop_data.mag > peak_reg)
                begin
                    peak_next = pop_data.mag;
                end
                fe_next = fe_sum[FRAME_E_W] ? '1 : fe_sum[FRAME_E_W-1:0];
            end
        end

        if (do_out)
        begin
            out_valid_next = 1'b1;
            out_data_next = '{sample_out: y, frame_zeroed: zero_reg, gate_closing: gate_reg};
            if (it_reg.last && !cfg.gate_enable)
            begin
                zero_next = 1'b0;
                gate_next = 1'b0;
                peak_next = '0;
                fe_next = '0;
            end
        end

        if (state_reg == ST_DEC)
        begin
            zero_next = 1'b0;
            gate_next = active;
            if (hold_reg != 8'd0)
            begin
                hold_next = hold_reg - 8'd1;
            end
            if (!active && quiet && (peak_reg > {1'b0, cfg.peak_limit}))
            begin
                hold_next = cfg.hold_frames;
                gate_next = 1'b1;
                zero_next = 1'b1;
                phase_next = '0;
            end
        end

        if (state_reg == ST_POP_SUB)
        begin
            wen_next = (wen_reg > WIN_E_W'(ring_rd_reg)) ? wen_reg - WIN_E_W'(ring_rd_reg) : '0;
            head_next = (head_reg == HEAD_W'(MAX_WINDOW_FRAMES - 1)) ? '0
                        : head_reg + HEAD_W'(1);
            fill_next = fill_reg - FILL_W'(1);
        end

        if (ring_we)
        begin
            fill_next = fill_reg + FILL_W'(1);
            wen_next = wen_sum[WIN_E_W] ? '1 : wen_sum[WIN_E_W-1:0];
            peak_next = '0;
            fe_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PHASE_W'(RAMP_STEPS);
            group_reg <= 3'd0;
            hold_reg <= 8'd0;
            zero_reg <= 1'b0;
            gate_reg <= 1'b0;
            peak_reg <= '0;
            fe_reg <= '0;
            wen_reg <= '0;
            fill_reg <= '0;
            head_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            group_reg <= group_next;
            hold_reg <= hold_next;
            zero_reg <= zero_next;
            gate_reg <= gate_next;
            peak_reg <= peak_next;
            fe_reg <= fe_next;
            wen_reg <= wen_next;
            fill_reg <= fill_next;
            head_reg <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg <= it_next;
        out_data_reg <= out_data_next;
        if (state_reg == ST_GAIN)
        begin
            gain_reg <= gain_rom[phase_reg];
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= it_reg.delayed * $signed({1'b0, gain_reg});
        end
        if (state_reg == ST_LIM1)
        begin
            flmul_reg <= MUL_W'(fill_reg) * MUL_W'(flen);
        end
        if (state_reg == ST_LIM2)
        begin
            limit_reg <= LIM_W'(cfg.quiet_energy_limit) * LIM_W'(flmul_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[wr_idx] <= fe_reg;
        end
        if (ring_re)
        begin
            ring_rd_reg <= ring_mem[head_reg];
        end
    end

    assign result_valid = out_valid_reg;
    assign result = out_data_reg;

endmodule

`default_nettype wire

FILE: sv/audio_click_squelch_gate_unit.sv
// Path: a sample passes the front register stage, the two-entry queue, and the gain lookup,
// multiply and output steps of the back sequencer, which end in the result register. The back
// sequencer takes one sample at a time while the front and queue may accept more. With the
// gate enabled, a frame's last sample adds the window update, retiring ring energy entries.
// Reset: configuration returns to its defaults and a clearing pass over all MAX_FRAME_SAMPLES
// entries zeroes the frame delay memory, during which no sample transfer is taken.
`default_nettype none

module audio_click_squelch_gate_unit #(
    parameter int MAX_FRAME_SAMPLES = acsg_pkg::DEF_MAX_FRAME_SAMPLES,
    parameter int MAX_WINDOW_FRAMES = acsg_pkg::DEF_MAX_WINDOW_FRAMES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  acsg_pkg::in_item_t            item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output acsg_pkg::out_item_t           result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [acsg_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import acsg_pkg::*;

    localparam int FLEN_W = $clog2(MAX_FRAME_SAMPLES) + 1;
    localparam int FILL_W = $clog2(MAX_WINDOW_FRAMES + 1);
    localparam int FS_W = (FLEN_W > 14) ? FLEN_W : 14;
    localparam int WF_W = (FILL_W > 7) ? FILL_W : 7;

    cfg_t              cfg_reg, cfg_next;
    logic              cfg_write;
    logic [3:0]        chans;
    logic [FLEN_W-1:0] flen;
    logic [FILL_W-1:0] wlen;
    logic [FS_W-1:0]   fs_ext;
    logic [WF_W-1:0]   wf_ext;

    logic              push_valid;
    logic              push_ready;
    q_entry_t          push_data;
    logic              pop_valid;
    logic              pop_ready;
    q_entry_t          pop_data;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (paddr[4:2])
                REG_GATE_ENABLE:   cfg_next.gate_enable = pwdata[0];
                REG_CHANNEL_COUNT: cfg_next.channel_count = pwdata[3:0];
                REG_FRAME_SAMPLES: cfg_next.frame_samples = pwdata[13:0];
                REG_WINDOW_FRAMES: cfg_next.window_frames = pwdata[6:0];
                REG_PEAK_LIMIT:    cfg_next.peak_limit = pwdata[14:0];
                REG_QUIET_LIMIT:   cfg_next.quiet_energy_limit = pwdata[29:0];
                REG_HOLD_FRAMES:   cfg_next.hold_frames = pwdata[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_GATE_ENABLE:   prdata = 32'(cfg_reg.gate_enable);
            REG_CHANNEL_COUNT: prdata = 32'(cfg_reg.channel_count);
            REG_FRAME_SAMPLES: prdata = 32'(cfg_reg.frame_samples);
            REG_WINDOW_FRAMES: prdata = 32'(cfg_reg.window_frames);
            REG_PEAK_LIMIT:    prdata = 32'(cfg_reg.peak_limit);
            REG_QUIET_LIMIT:   prdata = 32'(cfg_reg.quiet_energy_limit);
            REG_HOLD_FRAMES:   prdata = 32'(cfg_reg.hold_frames);
            default:           prdata = 32'd0;
        endcase
    end

    assign fs_ext = FS_W'(cfg_reg.frame_samples);
    assign wf_ext = WF_W'(cfg_reg.window_frames);

    always_comb
    begin
        if (cfg_reg.channel_count == 4'd0)
        begin
            chans = 4'd1;
        end
        else if (cfg_reg.channel_count > 4'(MAX_CHANNELS))
        begin
            chans = 4'(MAX_CHANNELS);
        end
        else
        begin
            chans = cfg_reg.channel_count;
        end

        if (fs_ext == '0)
        begin
            flen = FLEN_W'(1);
        end
        else if (fs_ext > FS_W'(MAX_FRAME_SAMPLES))
        begin
            flen = FLEN_W'(MAX_FRAME_SAMPLES);
        end
        else
        begin
            flen = FLEN_W'(fs_ext);
        end

        if (wf_ext == '0)
        begin
            wlen = FILL_W'(1);
        end
        else if (wf_ext > WF_W'(MAX_WINDOW_FRAMES))
        begin
            wlen = FILL_W'(MAX_WINDOW_FRAMES);
        end
        else
        begin
            wlen = FILL_W'(wf_ext);
        end
    end

    acsg_front #(
        .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .flen       (flen),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    acsg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    acsg_back #(
        .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES),
        .MAX_WINDOW_FRAMES (MAX_WINDOW_FRAMES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .chans        (chans),
        .flen         (flen),
        .wlen         (wlen),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

FILE: sim/audio_click_squelch_gate_unit_tb.sv
`timescale 1ns / 100ps

module audio_click_squelch_gate_unit_tb;
    import acsg_pkg::*;

    localparam int IDLE_LIMIT = 40000;
    localparam int WINDOW_UPDATE_CYCLES = 5 + 2 * DEF_MAX_WINDOW_FRAMES + 40;
    localparam int RANDOM_ITEMS = 900;
    localparam int MAX_PRINTED = 100;

    typedef enum int {
        FRAME_QUIET,
        FRAME_CLICK,
        FRAME_LOUD
    } frame_plan_t;

    class squelch_scoreboard;
        localparam longint unsigned FRAME_ENERGY_MAX = (64'd1 << FRAME_E_W) - 64'd1;
        localparam longint unsigned WINDOW_ENERGY_MAX = (64'd1 << WIN_E_W) - 64'd1;

        cfg_t settings;
        out_item_t expected_outputs[$];
        logic [15:0] delay_line [DEF_MAX_FRAME_SAMPLES];
        longint unsigned ring_energy [DEF_MAX_WINDOW_FRAMES];
        int unsigned gain_lut [RAMP_STEPS + 1];
        int unsigned ring_head;
        int unsigned window_fill;
        longint unsigned window_energy;
        longint unsigned frame_energy;
        int unsigned frame_peak;
        int unsigned sample_position;
        int unsigned group_position;
        int unsigned ramp_step;
        int unsigned hold_left;
        bit frame_zero_flag;
        bit frame_gate_flag;
        int unsigned results_seen;

        function new();
            settings = CFG_RESET;
            foreach (delay_line[i])
                delay_line[i] = '0;
            foreach (ring_energy[i])
                ring_energy[i] = 0;
            ring_head = 0;
            window_fill = 0;
            window_energy = 0;
            frame_energy = 0;
            frame_peak = 0;
            sample_position = 0;
            group_position = 0;
            ramp_step = RAMP_STEPS;
            hold_left = 0;
            frame_zero_flag = 0;
            frame_gate_flag = 0;
            results_seen = 0;
            for (int p = 0; p <= RAMP_STEPS; p++)
                gain_lut[p] = raised_cosine_gain(p);
        endfunction

        function int unsigned raised_cosine_gain(int unsigned p);
            int unsigned taylor_div [5];
            longint unsigned t;
            longint unsigned t2;
            longint unsigned f;
            longint unsigned s;
            longint unsigned g;
            taylor_div = '{110, 72, 42, 20, 6};
            if (p >= RAMP_STEPS)
                return 32768;
            t = (HALF_PI_Q30 * 64'(p)) / 64'(RAMP_STEPS);
            t2 = (t * t) >> 30;
            f = Q30_ONE;
            foreach (taylor_div[k])
                f = Q30_ONE - ((t2 * f) >> 30) / 64'(taylor_div[k]);
            s = (t * f) >> 30;
            if (s > Q30_ONE)
                s = Q30_ONE;
            g = (s * s) >> 30;
            g = (g + 64'd16384) >> 15;
            if (g > 64'd32768)
                g = 64'd32768;
            return 32'(g);
        endfunction

        function int unsigned clamp_setting(int unsigned v, int unsigned hi);
            if (v == 0)
                return 1;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function void write_setting(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_GATE_ENABLE: settings.gate_enable = value[0];
                REG_CHANNEL_COUNT: settings.channel_count = value[3:0];
                REG_FRAME_SAMPLES: settings.frame_samples = value[13:0];
                REG_WINDOW_FRAMES: settings.window_frames = value[6:0];
                REG_PEAK_LIMIT: settings.peak_limit = value[14:0];
                REG_QUIET_LIMIT: settings.quiet_energy_limit = value[29:0];
                REG_HOLD_FRAMES: settings.hold_frames = value[7:0];
                default: ;
            endcase
        endfunction

        function out_item_t predict_gated_sample(in_item_t it);
            int unsigned flen;
            int unsigned chans;
            int unsigned wlen;
            int unsigned pos;
            int sv;
            int mag;
            longint signed prod;
            longint unsigned sq;
            longint unsigned oldest;
            bit active;
            bit quiet;
            bit zero;
            out_item_t r;
            flen = clamp_setting(settings.frame_samples, DEF_MAX_FRAME_SAMPLES);
            chans = clamp_setting(settings.channel_count, MAX_CHANNELS);
            wlen = clamp_setting(settings.window_frames, DEF_MAX_WINDOW_FRAMES);
            pos = sample_position % DEF_MAX_FRAME_SAMPLES;
            sv = int'(it.sample_in);

            if (!settings.gate_enable)
                r.sample_out = delay_line[pos];
            else if (frame_zero_flag)
                r.sample_out = '0;
            else
            begin
                if (group_position == 0)
                begin
                    if (frame_gate_flag)
                    begin
                        if (ramp_step > 0)
                            ramp_step--;
                    end
                    else if (ramp_step < RAMP_STEPS)
                        ramp_step++;
                end
                prod = longint'($signed(delay_line[pos])) * longint'(gain_lut[ramp_step]);
                r.sample_out = 16'(((prod + 64'sd1073741824 + 64'sd16384) >>> 15)
                                   - 64'sd32768);
            end
            group_position = (group_position + 1 >= chans) ? 0 : group_position + 1;
            r.frame_zeroed = frame_zero_flag;
            r.gate_closing = frame_gate_flag;

            delay_line[pos] = it.sample_in;
            if (settings.gate_enable)
            begin
                mag = (sv < 0) ? -sv : sv;
                sq = 64'(longint'(sv) * longint'(sv));
                if (32'(mag) > frame_peak)
                    frame_peak = mag;
                frame_energy = (frame_energy > FRAME_ENERGY_MAX - sq) ?
                               FRAME_ENERGY_MAX : frame_energy + sq;
            end

            if (pos + 1 >= flen)
            begin
                sample_position = 0;
                group_position = 0;
                if (settings.gate_enable)
                begin
                    active = it.gate_armed || (hold_left != 0);
                    quiet = (window_fill == 0) ||
                            (window_energy < 64'(settings.quiet_energy_limit) *
                                             64'(window_fill) * 64'(flen));
                    zero = 0;
                    if (hold_left != 0)
                        hold_left--;
                    if (!active && quiet && frame_peak > settings.peak_limit)
                    begin
                        hold_left = settings.hold_frames;
                        active = 1;
                        zero = 1;
                        ramp_step = 0;
                    end
                    while (window_fill >= wlen)
                    begin
                        oldest = ring_energy[ring_head % DEF_MAX_WINDOW_FRAMES];
                        window_energy = (window_energy > oldest) ? window_energy - oldest : 0;
                        ring_head = (ring_head + 1) % DEF_MAX_WINDOW_FRAMES;
                        window_fill--;
                    end
                    ring_energy[(ring_head + window_fill) % DEF_MAX_WINDOW_FRAMES] = frame_energy;
                    window_fill++;
                    window_energy = (window_energy > WINDOW_ENERGY_MAX - frame_energy) ?
                                    WINDOW_ENERGY_MAX : window_energy + frame_energy;
                    frame_zero_flag = zero;
                    frame_gate_flag = active;
                end
                else
                begin
                    frame_zero_flag = 0;
                    frame_gate_flag = 0;
                end
                frame_peak = 0;
                frame_energy = 0;
            end
            else
                sample_position = pos + 1;
            return r;
        endfunction

        function void note_sample(in_item_t it);
            expected_outputs.insert(expected_outputs.size(), predict_gated_sample(it));
        endfunction

        function int outstanding();
            return expected_outputs.size();
        endfunction

        function string check_result(out_item_t got);
            out_item_t want;
            string diffs;
            results_seen++;
            if (expected_outputs.size() == 0)
                return $sformatf("result %0d arrived with nothing expected", results_seen);
            want = expected_outputs[0];
            expected_outputs.delete(0);
            diffs = "";
            if (got.sample_out !== want.sample_out)
                diffs = {diffs, $sformatf(" sample_out %0d/%0d",
                                          got.sample_out, want.sample_out)};
            if (got.frame_zeroed !== want.frame_zeroed)
                diffs = {diffs, $sformatf(" frame_zeroed %0b/%0b",
                                          got.frame_zeroed, want.frame_zeroed)};
            if (got.gate_closing !== want.gate_closing)
                diffs = {diffs, $sformatf(" gate_closing %0b/%0b",
                                          got.gate_closing, want.gate_closing)};
            if (diffs != "")
                diffs = $sformatf("result %0d got/expected:%s", results_seen, diffs);
            return diffs;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_ready;
    in_item_t item;
    logic result_valid;
    logic result_ready;
    out_item_t result;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    squelch_scoreboard sb;
    int error_count;
    int idle_cycles;
    bit send_no_idle;
    bit recv_no_idle;
    frame_plan_t frame_kind;
    int unsigned click_slot;
    bit frame_armed;
    int quiet_amp;

    logic [16:0] opening_items [8] = '{
        {16'h7FFF, 1'b0}, {16'h8000, 1'b1}, {16'h0000, 1'b0}, {16'hFFFF, 1'b1},
        {16'h0001, 1'b0}, {16'h5555, 1'b1}, {16'hAAAA, 1'b0}, {16'h8000, 1'b0}
    };

    // The first sample ends the long frame left open by the opening transfers.
    logic [16:0] squelch_items [17] = '{
        {16'h0064, 1'b0},
        {16'h8000, 1'b0}, {16'h0005, 1'b0}, {16'hFFFB, 1'b0}, {16'h0007, 1'b1},
        {16'h7FFF, 1'b0}, {16'h0000, 1'b0}, {16'h0000, 1'b0}, {16'h0000, 1'b0},
        {16'h8000, 1'b0}, {16'h7FFF, 1'b1}, {16'h8000, 1'b0}, {16'h0001, 1'b0},
        {16'h0000, 1'b0}, {16'h0000, 1'b0}, {16'h0000, 1'b0}, {16'h0000, 1'b0}
    };

    audio_click_squelch_gate_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(string what);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.write_setting(idx, value);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_sample(in_item_t it);
        int gap;
        gap = send_no_idle ? 0 : int'($urandom_range(0, 12));
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        sb.note_sample(it);
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        item_valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.outstanding() != 0);
    endtask

    // The window update of a frame's last sample may still run after its transfer.
    task automatic settle_block();
        wait_for_results();
        repeat (WINDOW_UPDATE_CYCLES) @(negedge clk);
    endtask

    function automatic void plan_frame(int unsigned flen);
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            frame_kind = FRAME_QUIET;
        else if (pick < 17)
            frame_kind = FRAME_CLICK;
        else
            frame_kind = FRAME_LOUD;
        click_slot = $urandom_range(0, flen - 1);
        frame_armed = ($urandom_range(0, 4) == 0);
    endfunction

    function automatic in_item_t next_sample();
        in_item_t it;
        int unsigned flen;
        int unsigned pos;
        int v;
        int lo;
        int mag;
        flen = sb.clamp_setting(sb.settings.frame_samples, DEF_MAX_FRAME_SAMPLES);
        pos = sb.sample_position % DEF_MAX_FRAME_SAMPLES;
        if (pos == 0)
            plan_frame(flen);
        if (frame_kind == FRAME_LOUD)
            v = int'($urandom_range(0, 65535)) - 32768;
        else if (frame_kind == FRAME_CLICK && pos == click_slot)
        begin
            lo = int'(sb.settings.peak_limit) + 1;
            mag = (lo > 32767) ? 32768 : int'($urandom_range(lo, 32768));
            v = (mag == 32768 || $urandom_range(0, 1) == 1) ? -mag : mag;
        end
        else
            v = int'($urandom_range(0, 2 * quiet_amp)) - quiet_amp;
        it.sample_in = 16'(v);
        it.gate_armed = (pos + 1 >= flen) ? frame_armed : 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic randomize_settings();
        logic [31:0] quiet_limit;
        int pick;
        write_reg(REG_GATE_ENABLE, 32'($urandom_range(0, 6) != 0));

        pick = $urandom_range(0, 9);
        write_reg(REG_CHANNEL_COUNT, (pick == 0) ? 0 : (pick == 1) ? 15 :
                  (pick == 2) ? $urandom_range(9, 14) : $urandom_range(1, 8));

        pick = $urandom_range(0, 19);
        write_reg(REG_FRAME_SAMPLES, (pick == 0) ? 0 : (pick == 1) ? 16383 :
                  (pick == 2) ? 8192 : (pick == 3) ? $urandom_range(8193, 16382) :
                  $urandom_range(1, 24));

        pick = $urandom_range(0, 9);
        write_reg(REG_WINDOW_FRAMES, (pick == 0) ? 0 : (pick == 1) ? 127 :
                  (pick == 2) ? 64 : (pick == 3) ? $urandom_range(65, 126) :
                  $urandom_range(1, 8));

        pick = $urandom_range(0, 7);
        write_reg(REG_PEAK_LIMIT, (pick == 0) ? 0 : (pick == 1) ? 32767 :
                  $urandom_range(16000, 32766));

        pick = $urandom_range(0, 9);
        if (pick == 0)
            quiet_limit = 0;
        else if (pick == 1)
            quiet_limit = 32'h3FFF_FFFF;
        else
            quiet_limit = (32'd1 << $urandom_range(2, 28)) | $urandom_range(0, 3);
        write_reg(REG_QUIET_LIMIT, quiet_limit);
        quiet_amp = int'($sqrt(real'(quiet_limit)));
        if (quiet_amp > 32767)
            quiet_amp = 32767;

        pick = $urandom_range(0, 9);
        write_reg(REG_HOLD_FRAMES, (pick == 0) ? 0 : (pick == 1) ? 255 :
                  $urandom_range(1, 6));

        send_no_idle = ($urandom_range(0, 3) == 0);
        recv_no_idle = ($urandom_range(0, 3) == 0);
    endtask

    initial
    begin
        int random_sent;
        int phase_items;
        int pause_at;
        int phase;
        sb = new();
        error_count = 0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_no_idle = 1'b0;
        recv_no_idle = 1'b0;
        frame_kind = FRAME_QUIET;
        click_slot = 0;
        frame_armed = 1'b0;
        quiet_amp = 32;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (opening_items[k])
            send_sample(in_item_t'(opening_items[k]));

        settle_block();
        write_reg(REG_GATE_ENABLE, 1);
        write_reg(REG_CHANNEL_COUNT, 0);
        write_reg(REG_FRAME_SAMPLES, 4);
        write_reg(REG_WINDOW_FRAMES, 0);
        write_reg(REG_PEAK_LIMIT, 32767);
        write_reg(REG_QUIET_LIMIT, 32'h3FFF_FFFF);
        write_reg(REG_HOLD_FRAMES, 2);
        foreach (squelch_items[k])
            send_sample(in_item_t'(squelch_items[k]));

        random_sent = 0;
        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            settle_block();
            randomize_settings();
            phase_items = $urandom_range(30, 90);
            if (phase == 0 || $urandom_range(0, 2) == 0)
                pause_at = $urandom_range(5, phase_items - 1);
            else
                pause_at = -1;
            for (int k = 0; k < phase_items; k++)
            begin
                if (k == pause_at)
                    wait_for_results();
                send_sample(next_sample());
            end
            random_sent += phase_items;
            phase++;
        end

        settle_block();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        string diffs;
        int gap;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = recv_no_idle ? 0 : int'($urandom_range(0, 12));
            if (gap > 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
            diffs = sb.check_result(result);
            if (diffs != "")
                report_mismatch(diffs);
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[%0t] watchdog: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
sv/acsg_pkg.sv
sv/acsg_front.sv
sv/acsg_queue.sv
sv/acsg_back.sv
sv/audio_click_squelch_gate_unit.sv
sim/audio_click_squelch_gate_unit_tb.sv
